>>> rtl/steq_pkg.sv
// ----------------------------------------------------------------------------
// steq_pkg
// Shared types and constants for the sorted timer expiry queue: queue
// sizing, result status codes, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package steq_pkg;

    // Queue sizing
    localparam int QUEUE_DEPTH  = 16;
    localparam int TASK_ID_BITS = 8;
    localparam int COUNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths of the ports
    localparam int TIME_W   = 32;
    localparam int TASK_W   = 8;
    localparam int STATUS_W = 2;

    // Request kinds
    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_TICK     = 1'b1;

    typedef logic [TIME_W-1:0]       time_t;
    typedef logic [TASK_ID_BITS-1:0] task_t;
    typedef logic [COUNT_W-1:0]      count_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_REGISTERED = 2'd0,
        STATUS_WOKEN      = 2'd1,
        STATUS_IDLE_TICK  = 2'd2,
        STATUS_FULL       = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REG,
        ST_TICK
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;       // capture a request
        logic    insert;     // insert the captured timer in order
        logic    pop;        // drop the head entry
        logic    out_load;   // load the result register
        status_t status;     // status of the loaded result
        logic    last;       // last marker of the loaded result
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;          // queue holds QUEUE_DEPTH entries
        logic head_expired;  // head entry is due at the captured time
        logic next_expired;  // entry after the head is due as well
        logic out_free;      // result register can take a new result
    } dp_status_t;

endpackage

>>> rtl/steq_ctrl.sv
// ----------------------------------------------------------------------------
// steq_ctrl
// Controller state machine: accepts one request at a time, then steers the
// datapath through an ordered insert or a sequence of head removals.
// ----------------------------------------------------------------------------
module steq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 req_type,
    input  steq_pkg::dp_status_t sts,
    output logic                 in_stall,
    output steq_pkg::dp_cmd_t    cmd
);

    steq_pkg::state_t state_reg;
    steq_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= steq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            steq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (req_type == steq_pkg::REQ_TICK) ?
                                 steq_pkg::ST_TICK : steq_pkg::ST_REG;
                end
            end
            steq_pkg::ST_REG:
            begin
                if (sts.out_free)
                begin
                    state_next = steq_pkg::ST_IDLE;
                end
            end
            steq_pkg::ST_TICK:
            begin
                if (sts.out_free && (!sts.head_expired || !sts.next_expired))
                begin
                    state_next = steq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = steq_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: hold off requests while busy, issue datapath commands
    always_comb
    begin
        in_stall     = 1'b1;
        cmd          = '0;
        cmd.status   = steq_pkg::STATUS_REGISTERED;
        unique case (state_reg)
            steq_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            steq_pkg::ST_REG:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.last     = 1'b1;
                    cmd.insert   = !sts.full;
                    cmd.status   = sts.full ? steq_pkg::STATUS_FULL :
                                              steq_pkg::STATUS_REGISTERED;
                end
            end
            steq_pkg::ST_TICK:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.head_expired)
                    begin
                        cmd.pop    = 1'b1;
                        cmd.status = steq_pkg::STATUS_WOKEN;
                        cmd.last   = !sts.next_expired;
                    end
                    else
                    begin
                        cmd.status = steq_pkg::STATUS_IDLE_TICK;
                        cmd.last   = 1'b1;
                    end
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/steq_datapath.sv
// ----------------------------------------------------------------------------
// steq_datapath
// Request capture, sorted entry registers with ordered insert and head
// removal, entry count, and the result register towards the output channel.
// ----------------------------------------------------------------------------
module steq_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  steq_pkg::dp_cmd_t                    cmd,
    input  logic [steq_pkg::TIME_W-1:0]          delay,
    input  logic [steq_pkg::TIME_W-1:0]          now,
    input  logic [steq_pkg::TASK_W-1:0]          task_id,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic [steq_pkg::STATUS_W-1:0]        status,
    output logic [steq_pkg::TASK_W-1:0]          woken_task,
    output logic                                 last,
    output steq_pkg::dp_status_t                 sts
);

    // Captured request
    steq_pkg::time_t  now_reg;
    steq_pkg::time_t  expiry_reg;
    steq_pkg::task_t  task_reg;

    // Sorted entries, valid below count_reg
    steq_pkg::time_t  exp_reg  [steq_pkg::QUEUE_DEPTH];
    steq_pkg::task_t  tsk_reg  [steq_pkg::QUEUE_DEPTH];
    steq_pkg::time_t  exp_next [steq_pkg::QUEUE_DEPTH];
    steq_pkg::task_t  tsk_next [steq_pkg::QUEUE_DEPTH];
    steq_pkg::count_t count_reg;
    steq_pkg::count_t count_next;

    // Insert position flags
    logic [steq_pkg::QUEUE_DEPTH-1:0] at_or_after;
    logic [steq_pkg::QUEUE_DEPTH-1:0] prev_after;

    // Result register
    logic                        out_valid_reg;
    steq_pkg::status_t           status_reg;
    logic [steq_pkg::TASK_W-1:0] woken_reg;
    logic [steq_pkg::TASK_W-1:0] woken_next;
    logic                        last_reg;

    // Capture the request and form its expiry (wraps modulo 2^32)
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg    <= now;
            expiry_reg <= delay + now;
            task_reg   <= steq_pkg::TASK_ID_BITS'(task_id);
        end
    end

    // Mark slots at or beyond the insert point: free slots, or a later expiry
    always_comb
    begin
        for (int i = 0; i < steq_pkg::QUEUE_DEPTH; i++)
        begin
            at_or_after[i] = (steq_pkg::COUNT_W'(i) >= count_reg) ||
                             (exp_reg[i] > expiry_reg);
        end
        prev_after[0] = 1'b0;
        for (int i = 1; i < steq_pkg::QUEUE_DEPTH; i++)
        begin
            prev_after[i] = at_or_after[i-1];
        end
    end

    // Next entry contents: shift right for insert, shift left for pop
    always_comb
    begin
        for (int i = 0; i < steq_pkg::QUEUE_DEPTH; i++)
        begin
            exp_next[i] = exp_reg[i];
            tsk_next[i] = tsk_reg[i];
            if (cmd.insert && at_or_after[i] && !prev_after[i])
            begin
                exp_next[i] = expiry_reg;
                tsk_next[i] = task_reg;
            end
        end
        for (int i = 1; i < steq_pkg::QUEUE_DEPTH; i++)
        begin
            if (cmd.insert && prev_after[i])
            begin
                exp_next[i] = exp_reg[i-1];
                tsk_next[i] = tsk_reg[i-1];
            end
        end
        for (int i = 0; i < steq_pkg::QUEUE_DEPTH - 1; i++)
        begin
            if (cmd.pop)
            begin
                exp_next[i] = exp_reg[i+1];
                tsk_next[i] = tsk_reg[i+1];
            end
        end
    end

    // Entry registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < steq_pkg::QUEUE_DEPTH; i++)
        begin
            exp_reg[i] <= exp_next[i];
            tsk_reg[i] <= tsk_next[i];
        end
    end

    // Advance the entry count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + steq_pkg::COUNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - steq_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Status towards the controller
    always_comb
    begin
        sts.full         = (count_reg == steq_pkg::COUNT_W'(steq_pkg::QUEUE_DEPTH));
        sts.head_expired = (count_reg != '0) && (exp_reg[0] <= now_reg);
        sts.next_expired = (count_reg > steq_pkg::COUNT_W'(1)) &&
                           (exp_reg[1] <= now_reg);
        sts.out_free     = !out_valid_reg || !out_stall;
    end

    // Woken task only on a woken result
    always_comb
    begin
        woken_next = '0;
        if (cmd.status == steq_pkg::STATUS_WOKEN)
        begin
            woken_next = steq_pkg::TASK_W'(tsk_reg[0]);
        end
    end

    // Result register: load a new result, drop it once transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg <= cmd.status;
            woken_reg  <= woken_next;
            last_reg   <= cmd.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign woken_task = woken_reg;
    assign last       = last_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= steq_pkg::COUNT_W'(steq_pkg::QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (count_reg != '0))
        else $error("head removed from an empty queue");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> !sts.full)
        else $error("insert into a full queue");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("pending result overwritten");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> (count_reg == $past(count_reg) + steq_pkg::COUNT_W'(1)))
        else $error("entry count not advanced by insert");

endmodule

>>> rtl/sorted_timer_expiry_queue.sv
// ----------------------------------------------------------------------------
// sorted_timer_expiry_queue
// Bounded queue of pending timers kept sorted by absolute expiry time, with
// ordered insert on register requests and in-order wake-up on ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries req_type, delay, now and
//   task_id. A register request stores a timer expiring at delay + now,
//   after every entry with an equal or earlier expiry; it is refused with
//   status 3 when the queue is full. A tick request removes every entry due
//   at or before now and returns their task ids in queue order.
//   Output channel (out_valid / out_stall) carries status, woken_task and
//   last; last marks the final result of each request. A tick with nothing
//   due returns a single status 2 result.
//   Timing: one request is in work at a time. A register request first
//   forms its expiry add in the capture registers, then does the parallel
//   compare and shift insert as its result is loaded. A tick makes one head
//   removal per cycle, waiting whenever the result register is stalled.
//   in_stall is low only while the controller is idle.
//   A stalled receiver holds the result register; the queue waits for it.
//   Reset clears the entry count and all control state; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_timer_expiry_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [steq_pkg::TIME_W-1:0]   delay,
    input  logic [steq_pkg::TIME_W-1:0]   now,
    input  logic [steq_pkg::TASK_W-1:0]   task_id,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [steq_pkg::STATUS_W-1:0] status,
    output logic [steq_pkg::TASK_W-1:0]   woken_task,
    output logic                          last
);

    steq_pkg::dp_cmd_t    cmd;
    steq_pkg::dp_status_t sts;

    // Controller
    steq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // Datapath
    steq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .delay      (delay),
        .now        (now),
        .task_id    (task_id),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .status     (status),
        .woken_task (woken_task),
        .last       (last),
        .sts        (sts)
    );

endmodule
